/* design/uws_pkg.sv */
// ---------------------------------------------------------------------------
// uws_pkg: shared types and constants for the UTF-8 whitespace scanner
// Beat layouts, byte codes and class codes used by the decoder, the result
// serializer and the top level.
// ---------------------------------------------------------------------------
package uws_pkg;

    localparam logic [7:0] LEAD_NBSP    = 8'hC2;
    localparam logic [7:0] LEAD_WIDE    = 8'hE2;
    localparam logic [7:0] TAIL_NBSP    = 8'hA0;
    localparam logic [7:0] MID_WIDE     = 8'h80;
    localparam logic [7:0] TAIL_WIDE_HI = 8'h83;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_VAL     = 8'h80;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_TAB     = 8'h09;

    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_SPACE = 3'd1;
    localparam logic [2:0] CLS_TAB   = 3'd2;
    localparam logic [2:0] CLS_NBSP  = 3'd3;
    localparam logic [2:0] CLS_QUAD  = 3'd4;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  char_class;
        logic        first_of_unit;
        logic        run_member;
        logic [31:0] line_number;
        logic [31:0] column_number;
        logic        last_of_item;
    } t_out_beat;

    // One classified byte, before line and column are attached.
    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] cls;
        logic       first;
        logic       run;
    } t_ent;

    // All results caused by one input byte, in stream order.
    typedef struct packed {
        t_ent [2:0] ents;
        logic [1:0] cnt;
    } t_group;

endpackage

/* design/uws_decode.sv */
// ---------------------------------------------------------------------------
// uws_decode: lead byte hold buffer and byte classifier
// Keeps up to two held bytes of an open sequence and turns each accepted
// input byte into its group of up to three classified bytes.
// ---------------------------------------------------------------------------
module uws_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  uws_pkg::t_in_beat i_data,
    input  logic            i_tab_ws,
    output uws_pkg::t_group o_group,
    output logic [1:0]      o_held_cnt
);
    import uws_pkg::*;

    logic [7:0] r_held [2];
    logic [1:0] r_held_cnt;
    logic [7:0] n_held [2];
    logic [1:0] n_held_cnt;
    t_ent [3:0] w_ents;
    logic [1:0] w_n;
    logic       w_taken;
    logic [7:0] w_b;

    function automatic t_ent mk_ent(logic [7:0] ch, logic [2:0] cls, logic first,
                                    logic run);
        t_ent e;
        e.ch    = ch;
        e.cls   = cls;
        e.first = first;
        e.run   = run;
        return e;
    endfunction

    assign w_b = i_data.byte_value;

    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        w_ents     = '0;
        w_n        = 2'd0;
        w_taken    = 1'b0;

        if (r_held_cnt == 2'd1 && r_held[0] == LEAD_NBSP) begin
            if (w_b == TAIL_NBSP) begin
                w_ents[0]  = mk_ent(LEAD_NBSP, CLS_NBSP, 1'b1, 1'b1);
                w_ents[1]  = mk_ent(w_b, CLS_NBSP, 1'b0, 1'b1);
                w_n        = 2'd2;
                w_taken    = 1'b1;
            end else begin
                w_ents[0]  = mk_ent(r_held[0], CLS_OTHER, 1'b1, 1'b0);
                w_n        = 2'd1;
            end
            n_held_cnt = 2'd0;
        end else if (r_held_cnt == 2'd1 && r_held[0] == LEAD_WIDE) begin
            if (w_b == MID_WIDE) begin
                n_held[1]  = w_b;
                n_held_cnt = 2'd2;
                w_taken    = 1'b1;
            end else begin
                w_ents[0]  = mk_ent(r_held[0], CLS_OTHER, 1'b1, 1'b0);
                w_n        = 2'd1;
                n_held_cnt = 2'd0;
            end
        end else if (r_held_cnt == 2'd2 && r_held[0] == LEAD_WIDE
                     && r_held[1] == MID_WIDE) begin
            if (w_b >= MID_WIDE && w_b <= TAIL_WIDE_HI) begin
                w_ents[0] = mk_ent(LEAD_WIDE, CLS_QUAD, 1'b1, 1'b1);
                w_ents[1] = mk_ent(MID_WIDE, CLS_QUAD, 1'b0, 1'b1);
                w_ents[2] = mk_ent(w_b, CLS_QUAD, 1'b0, 1'b1);
                w_n       = 2'd3;
                w_taken   = 1'b1;
            end else begin
                w_ents[0] = mk_ent(r_held[0], CLS_OTHER, 1'b1, 1'b0);
                w_ents[1] = mk_ent(r_held[1], CLS_OTHER, 1'b1, 1'b0);
                w_n       = 2'd2;
            end
            n_held_cnt = 2'd0;
        end else if (r_held_cnt != 2'd0) begin
            // Held contents that no valid sequence leaves behind are flushed.
            w_ents[0] = mk_ent(r_held[0], CLS_OTHER, 1'b1, 1'b0);
            w_ents[1] = mk_ent(r_held[1], CLS_OTHER, 1'b1, 1'b0);
            w_n       = (r_held_cnt == 2'd1) ? 2'd1 : 2'd2;
            n_held_cnt = 2'd0;
        end

        if (!w_taken) begin
            if (w_b == LEAD_NBSP || w_b == LEAD_WIDE) begin
                n_held[0]  = w_b;
                n_held_cnt = 2'd1;
            end else begin
                if (w_b == CHAR_SPACE || w_b == CHAR_LF || w_b == CHAR_CR) begin
                    w_ents[w_n] = mk_ent(w_b, CLS_SPACE, 1'b1, 1'b1);
                end else if (w_b == CHAR_TAB) begin
                    w_ents[w_n] = mk_ent(w_b, CLS_TAB, 1'b1, i_tab_ws);
                end else begin
                    w_ents[w_n] = mk_ent(w_b, CLS_OTHER, 1'b1, 1'b0);
                end
                w_n = w_n + 2'd1;
            end
        end

        // End of buffer: nothing may stay held.
        if (i_data.last_byte) begin
            if (n_held_cnt != 2'd0) begin
                w_ents[w_n] = mk_ent(n_held[0], CLS_OTHER, 1'b1, 1'b0);
                w_n = w_n + 2'd1;
            end
            if (n_held_cnt == 2'd2) begin
                w_ents[w_n] = mk_ent(n_held[1], CLS_OTHER, 1'b1, 1'b0);
                w_n = w_n + 2'd1;
            end
            n_held_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
        end else if (i_accept) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

    assign o_group.ents = w_ents[2:0];
    assign o_group.cnt  = w_n;
    assign o_held_cnt   = r_held_cnt;

endmodule

/* design/uws_serial.sv */
// ---------------------------------------------------------------------------
// uws_serial: result group register and output stage
// Holds one group of classified bytes and sends them out one beat at a
// time, attaching the saturating line and column counters.
// ---------------------------------------------------------------------------
module uws_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  uws_pkg::t_group   i_group,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output uws_pkg::t_out_beat o_out_data
);
    import uws_pkg::*;

    t_group     r_grp;
    logic       r_grp_valid;
    logic [1:0] r_idx;
    t_out_beat  r_out;
    logic       r_out_valid;
    logic [31:0] r_line;
    logic [31:0] r_col;

    logic       w_out_load;
    logic       w_take;
    logic       w_last;
    logic       w_done;
    t_ent       w_ent;

    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_take     = r_grp_valid && w_out_load;
    assign w_last     = (r_idx == r_grp.cnt - 2'd1);
    assign w_done     = w_take && w_last;
    assign w_ent      = r_grp.ents[r_idx];
    assign o_free     = !r_grp_valid || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (i_load) begin
            r_grp_valid <= 1'b1;
            r_idx       <= 2'd0;
        end else if (w_done) begin
            r_grp_valid <= 1'b0;
        end else if (w_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.out_byte      <= w_ent.ch;
            r_out.char_class    <= w_ent.cls;
            r_out.first_of_unit <= w_ent.first;
            r_out.run_member    <= w_ent.run;
            r_out.line_number   <= r_line;
            r_out.column_number <= r_col;
            r_out.last_of_item  <= w_last;
        end
    end

    // Continuation bytes leave both counters alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= 32'd1;
            r_col  <= 32'd1;
        end else if (w_take && ((w_ent.ch & CONT_MASK) != CONT_VAL)) begin
            if (w_ent.ch == CHAR_LF) begin
                if (r_line != COUNT_MAX) begin
                    r_line <= r_line + 32'd1;
                end
                r_col <= 32'd1;
            end else if (r_col != COUNT_MAX) begin
                r_col <= r_col + 32'd1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* design/utf8_whitespace_scanner.sv */
// ---------------------------------------------------------------------------
// utf8_whitespace_scanner: UTF-8 whitespace classifier with line/column
// Classifies each byte of a UTF-8 stream (space/LF/CR, tab, C2 A0, E2 80
// 80..83), holding back lead bytes until a sequence resolves, and reports
// every byte in order with its line and column.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+--------------------------
//   in      | input     | i_in_valid/o_in_stall   | t_in_beat
//   out     | output    | o_out_valid/i_out_stall | t_out_beat
//   cfg     | input     | i_cfg_valid/o_cfg_ready | tab_is_whitespace
//
// An input byte is decoded in the cycle it is accepted and its group of
// zero to three results is registered. While the output does not stall,
// results leave one beat per cycle and single-result bytes stream at one
// per cycle; a byte with k results holds the group register until all k
// have gone to the output stage, which sets the rate. Results pass the
// group and output registers in turn. Reset sets the counters to 1, empties
// the hold buffer and sets tab_is_whitespace to 1. An output stall holds
// the output register and stalls the input once the group register is full.
// ---------------------------------------------------------------------------
module utf8_whitespace_scanner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  uws_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output uws_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import uws_pkg::*;

    logic       r_tab_ws;
    logic       w_in_accept;
    logic       w_free;
    logic [1:0] w_held_cnt;
    t_group     w_group;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_ws <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tab_ws <= i_cfg_data;
        end
    end

    assign o_in_stall  = !w_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    uws_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_in_accept),
        .i_data     (i_in_data),
        .i_tab_ws   (r_tab_ws),
        .o_group    (w_group),
        .o_held_cnt (w_held_cnt)
    );

    uws_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_in_accept && (w_group.cnt != 2'd0)),
        .i_group     (w_group),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_flush_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && i_in_data.last_byte |=> w_held_cnt == 2'd0)
        else $error("held bytes remain after end of buffer");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_held_cnt != 2'd3)
        else $error("hold buffer count out of range");

    a_counts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.line_number != 32'd0
                         && o_out_data.column_number != 32'd0))
        else $error("line or column reported as zero");

endmodule

/* dv/utf8_whitespace_scanner_checker.sv */
// ---------------------------------------------------------------------------
// utf8_whitespace_scanner_checker: result predictor and comparator
// Watches the input, output and mode channels of the scanner. It keeps its own
// copy of the hold buffer, line/column counters and tab mode, and predicts
// the result beats caused by every accepted byte. Each result beat is then
// compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module utf8_whitespace_scanner_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  uws_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  uws_pkg::t_out_beat i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_data,
    input  logic               i_end_check,
    output int                 o_pending,
    output int                 o_errors
);
    import uws_pkg::*;

    localparam int MAX_PRINTED = 40;

    logic [31:0] line_cnt = 32'd1;
    logic [31:0] col_cnt  = 32'd1;
    logic [7:0]  held [2];
    logic [1:0]  held_cnt = 2'd0;
    logic        tab_joins_run = 1'b1;

    t_out_beat   byte_reports [$];
    t_out_beat   step_beats [4];
    int          step_n;
    int          err_cnt = 0;
    bit          leftover_done = 1'b0;

    task automatic log_mismatch(input string msg);
        if (err_cnt < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Attaches the current line and column, then advances the counters.
    // Continuation bytes do not move the column.
    task automatic append_result(input logic [7:0] value, input logic [2:0] cls,
                                 input logic first, input logic run);
        t_out_beat r;
        r.out_byte      = value;
        r.char_class    = cls;
        r.first_of_unit = first;
        r.run_member    = run;
        r.line_number   = line_cnt;
        r.column_number = col_cnt;
        r.last_of_item  = 1'b0;
        step_beats[step_n] = r;
        step_n++;
        if ((value & CONT_MASK) != CONT_VAL) begin
            if (value == CHAR_LF) begin
                if (line_cnt != COUNT_MAX) line_cnt++;
                col_cnt = 32'd1;
            end else if (col_cnt != COUNT_MAX) begin
                col_cnt++;
            end
        end
    endtask

    task automatic flush_held();
        for (int k = 0; k < held_cnt; k++)
            append_result(held[k], CLS_OTHER, 1'b1, 1'b0);
        held_cnt = 2'd0;
    endtask

    task automatic scan_byte(input logic [7:0] value, input logic is_last);
        bit taken;
        taken  = 1'b0;
        step_n = 0;
        if (held_cnt == 2'd1 && held[0] == LEAD_NBSP) begin
            if (value == TAIL_NBSP) begin
                append_result(LEAD_NBSP, CLS_NBSP, 1'b1, 1'b1);
                append_result(value, CLS_NBSP, 1'b0, 1'b1);
                held_cnt = 2'd0;
                taken    = 1'b1;
            end else begin
                flush_held();
            end
        end else if (held_cnt == 2'd1 && held[0] == LEAD_WIDE) begin
            if (value == MID_WIDE) begin
                held[1]  = value;
                held_cnt = 2'd2;
                taken    = 1'b1;
            end else begin
                flush_held();
            end
        end else if (held_cnt == 2'd2 && held[0] == LEAD_WIDE && held[1] == MID_WIDE) begin
            if (value >= MID_WIDE && value <= TAIL_WIDE_HI) begin
                append_result(LEAD_WIDE, CLS_QUAD, 1'b1, 1'b1);
                append_result(MID_WIDE, CLS_QUAD, 1'b0, 1'b1);
                append_result(value, CLS_QUAD, 1'b0, 1'b1);
                held_cnt = 2'd0;
                taken    = 1'b1;
            end else begin
                flush_held();
            end
        end else if (held_cnt != 2'd0) begin
            flush_held();
        end

        // A byte that broke a held sequence is treated as a fresh byte.
        if (!taken) begin
            if (value == LEAD_NBSP || value == LEAD_WIDE) begin
                held[0]  = value;
                held_cnt = 2'd1;
            end else if (value == CHAR_SPACE || value == CHAR_LF || value == CHAR_CR) begin
                append_result(value, CLS_SPACE, 1'b1, 1'b1);
            end else if (value == CHAR_TAB) begin
                append_result(value, CLS_TAB, 1'b1, tab_joins_run);
            end else begin
                append_result(value, CLS_OTHER, 1'b1, 1'b0);
            end
        end

        if (is_last) flush_held();

        if (step_n > 0) step_beats[step_n-1].last_of_item = 1'b1;
        for (int k = 0; k < step_n; k++)
            byte_reports.push_back(step_beats[k]);
    endtask

    // Output beats are checked before the same edge's input is predicted, so a
    // beat can never be matched against a byte accepted at that very edge.
    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        if (!i_rst_n) begin
            line_cnt      = 32'd1;
            col_cnt       = 32'd1;
            held_cnt      = 2'd0;
            held[0]       = 8'h00;
            held[1]       = 8'h00;
            tab_joins_run = 1'b1;
            byte_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (byte_reports.size() == 0) begin
                    log_mismatch($sformatf("result beat with byte %0h and nothing expected",
                                           i_out_data.out_byte));
                end else begin
                    want = byte_reports.pop_front();
                    check_field("out_byte", 32'(i_out_data.out_byte),
                                32'(want.out_byte));
                    check_field("char_class", 32'(i_out_data.char_class),
                                32'(want.char_class));
                    check_field("first_of_unit", 32'(i_out_data.first_of_unit),
                                32'(want.first_of_unit));
                    check_field("run_member", 32'(i_out_data.run_member),
                                32'(want.run_member));
                    check_field("line_number", i_out_data.line_number, want.line_number);
                    check_field("column_number", i_out_data.column_number,
                                want.column_number);
                    check_field("last_of_item", 32'(i_out_data.last_of_item),
                                32'(want.last_of_item));
                end
            end
            if (i_in_valid && !i_in_stall)
                scan_byte(i_in_data.byte_value, i_in_data.last_byte);
            // A mode write takes effect for bytes accepted after this edge.
            if (i_cfg_valid && i_cfg_ready) tab_joins_run = i_cfg_data;
            if (i_end_check && !leftover_done) begin
                leftover_done = 1'b1;
                if (byte_reports.size() != 0)
                    log_mismatch($sformatf("%0d expected result beats never arrived",
                                           byte_reports.size()));
            end
        end
        o_pending <= byte_reports.size();
        o_errors  <= err_cnt;
    end

endmodule

/* dv/utf8_whitespace_scanner_tb.sv */
// ---------------------------------------------------------------------------
// utf8_whitespace_scanner_tb: stimulus and verdict for the whitespace scanner
// Drives a directed set of whitespace, broken-sequence and end-of-buffer
// bytes, then random UTF-8 text mixed with noise, in both tab modes, with
// random sender gaps and receiver stalls. Checking is done by the checker.
// ---------------------------------------------------------------------------
module utf8_whitespace_scanner_tb;
    import uws_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;

    // {last_byte, byte_value}
    localparam logic [8:0] DIRECTED [25] = '{
        9'h000, 9'h0FF, 9'h020, 9'h00A, 9'h00D, 9'h009,
        9'h0C2, 9'h0A0,
        9'h0E2, 9'h080, 9'h083,
        9'h0C2, 9'h041,
        9'h0E2, 9'h081,
        9'h0E2, 9'h080, 9'h084,
        9'h0E2, 9'h0E2, 9'h080, 9'h080,
        9'h1C2,
        9'h0E2, 9'h180
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    logic      end_check;
    int        pending;
    int        errors;

    bit        idle_en = 1'b1;
    int        stall_left = 0;
    int        sent = 0;
    int        quiet = 0;
    int        out_beats = 0;

    always #1 clk = ~clk;

    utf8_whitespace_scanner dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    utf8_whitespace_scanner_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_end_check (end_check),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Receiver stalls come in bursts whose length is drawn at random.
    always @(negedge clk) begin
        if (!idle_en) stall_left = 0;
        else if (stall_left > 0) stall_left--;
        else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (out_valid && !out_stall) out_beats <= out_beats + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL utf8_whitespace_scanner");
            $finish;
        end
    end

    // Called right after a falling edge; returns right after a falling edge.
    // Valid stays high after the beat so back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int       gap;
        t_in_beat beat;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
        beat.byte_value = value;
        beat.last_byte  = is_last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_text_byte(input logic [7:0] value);
        send_byte(value, $urandom_range(0, 24) == 0);
    endtask

    // Mostly well-formed text and whitespace units, plus broken sequences
    // and raw noise bytes.
    task automatic send_random_seq();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 2))
                0: send_text_byte(CHAR_SPACE);
                1: send_text_byte(CHAR_LF);
                default: send_text_byte(CHAR_CR);
            endcase
        end else if (pick < 18) begin
            send_text_byte(CHAR_TAB);
        end else if (pick < 28) begin
            send_text_byte(LEAD_NBSP);
            send_text_byte(TAIL_NBSP);
        end else if (pick < 40) begin
            send_text_byte(LEAD_WIDE);
            send_text_byte(MID_WIDE);
            send_text_byte(MID_WIDE + 8'($urandom_range(0, 3)));
        end else if (pick < 52) begin
            send_text_byte(8'($urandom_range(8'h21, 8'h7E)));
        end else if (pick < 60) begin
            send_text_byte(8'($urandom_range(8'hC2, 8'hDF)));
            send_text_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 66) begin
            send_text_byte(8'($urandom_range(8'hE0, 8'hEF)));
            send_text_byte(8'($urandom_range(8'h80, 8'hBF)));
            send_text_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 72) begin
            send_text_byte(LEAD_NBSP);
            send_text_byte(8'($urandom_range(0, 255)));
        end else if (pick < 78) begin
            send_text_byte(LEAD_WIDE);
            send_text_byte(8'($urandom_range(0, 255)));
        end else if (pick < 84) begin
            send_text_byte(LEAD_WIDE);
            send_text_byte(MID_WIDE);
            send_text_byte(8'($urandom_range(0, 255)));
        end else begin
            send_text_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count, input bit allow_idle);
        int target;
        int seqs;
        target = sent + count;
        seqs   = 0;
        idle_en = allow_idle;
        while (sent < target) begin
            // Alternate stretches with and without gaps and stalls.
            if (allow_idle && seqs % 20 == 0) idle_en = ($urandom_range(0, 3) != 0);
            send_random_seq();
            seqs++;
        end
    endtask

    // Waits until every predicted beat has come, then lets the block settle
    // in case the last bytes were only held.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_tab_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        end_check = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bytes run in the reset mode, where a tab joins a run.
        foreach (DIRECTED[k]) send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);

        wait_drained();
        write_tab_mode(1'b0);
        send_byte(CHAR_TAB, 1'b0);
        run_random(150, 1'b1);

        wait_drained();
        write_tab_mode(1'b1);
        run_random(150, 1'b1);

        wait_drained();
        write_tab_mode(1'b0);
        run_random(150, 1'b0);
        send_byte(8'h41, 1'b1);

        wait_drained();
        end_check <= 1'b1;
        @(posedge clk);
        @(posedge clk);

        $display("Run covered %0d input bytes and %0d result beats in both tab modes,",
                 sent, out_beats);
        $display("including held leads, broken sequences and end-of-buffer flushes.");
        if (errors == 0)
            $display("PASS utf8_whitespace_scanner");
        else
            $display("FAIL utf8_whitespace_scanner");
        $finish;
    end

endmodule
